// ----- hdl/mpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared widths, register map and constants of the Mandelbrot point collector.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned PROD_W    = 2 * COORD_W;
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned ITER_W    = 16;
  localparam int unsigned COUNT_W   = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // escape threshold: |z|^2 >= 4.0 in Q8.56
  localparam logic [PROD_W:0] ESCAPE_SQ = (PROD_W+1)'(1) << (2 * FRAC_BITS + 2);

  localparam logic [0:0] REG_ITER_LIMIT  = 1'd0;
  localparam logic [0:0] REG_POINT_LIMIT = 1'd1;

  localparam logic [ITER_W-1:0]  ITER_LIMIT_RST  = 16'd4000;
  localparam logic [COUNT_W-1:0] POINT_LIMIT_RST = 32'd1024;

endpackage

// ----- hdl/mpc_mul.sv -----
// ----------------------------------------------------------------------------
// mpc_mul
// Shared signed 32x32 multiplier with registered 64-bit product.
// ----------------------------------------------------------------------------
module mpc_mul (
  input  logic           clk,
  input  mpc_pkg::coord_t a,
  input  mpc_pkg::coord_t b,
  output mpc_pkg::prod_t  p
);

  mpc_pkg::prod_t p_r;

  always_ff @(posedge clk) begin
    p_r <= mpc_pkg::prod_t'(a) * mpc_pkg::prod_t'(b);
  end

  assign p = p_r;

endmodule

// ----- hdl/mandelbrot_point_collector.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_point_collector
// Escape-time membership test of candidate points, collecting members.
// ----------------------------------------------------------------------------
//  channel  dir  ports                 item
//  in       in   in_t*   (tdata 64)    c_real, c_imag
//  out      out  out_t*  (tdata 96)    point_real, point_imag, slot; tuser limit_reached
//  cfg      in   cfg_p*  (APB, 32)     0x0 iteration_limit, 0x4 point_limit
//
//  One shared multiplier runs every round through the steps zr*zi, update,
//  zr^2, zi^2 and compare; a point runs rounds until it escapes or reaches
//  iteration_limit, and a member then passes through an emit step.
//  in_tready is high only when idle.
//  Reset is synchronous, active low, and clears count and control state.
//  A member waits in the emit step while the output register is still full.
// ----------------------------------------------------------------------------
module mandelbrot_point_collector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // c_real [31:0], c_imag [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,    // point_real [31:0], point_imag [63:32], slot [95:64]
  output logic        out_tuser,    // limit_reached [0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RI   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_RR   = 3'd3;
  localparam logic [2:0] S_II   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam int unsigned CW = mpc_pkg::COORD_W;
  localparam int unsigned PW = mpc_pkg::PROD_W;

  localparam logic [mpc_pkg::ITER_W-1:0]  ITER_ONE  = 1;
  localparam logic [mpc_pkg::COUNT_W-1:0] COUNT_ONE = 1;

  logic [2:0]                  state_r, state_nxt;
  logic [mpc_pkg::ITER_W-1:0]  iter_limit_r, iter_limit_nxt;
  logic [mpc_pkg::COUNT_W-1:0] point_limit_r, point_limit_nxt;
  logic [mpc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [mpc_pkg::ITER_W-1:0]  n_r, n_nxt;
  logic                        out_valid_r, out_valid_nxt;

  mpc_pkg::coord_t cr_r, cr_nxt, ci_r, ci_nxt;
  mpc_pkg::coord_t zr_r, zr_nxt, zi_r, zi_nxt;
  mpc_pkg::prod_t  rr_r, rr_nxt, ii_r, ii_nxt;
  logic [95:0]     out_data_r, out_data_nxt;
  logic            out_user_r, out_user_nxt;

  mpc_pkg::coord_t mul_a, mul_b;
  mpc_pkg::prod_t  prod;
  logic signed [PW-1:0] re_sum, im_sum;
  logic [PW:0]          mag;
  logic                 cfg_wr;
  logic [0:0]           cfg_idx;

  function automatic mpc_pkg::coord_t sat32(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi, lo;
    hi = PW'($signed({1'b0, {(CW-1){1'b1}}}));
    lo = PW'($signed({1'b1, {(CW-1){1'b0}}}));
    if (v > hi) sat32 = hi[CW-1:0];
    else if (v < lo) sat32 = lo[CW-1:0];
    else sat32 = v[CW-1:0];
  endfunction

  mpc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    case (state_r)
      S_RR:    begin mul_a = zr_r; mul_b = zr_r; end
      S_II:    begin mul_a = zi_r; mul_b = zi_r; end
      default: begin mul_a = zr_r; mul_b = zi_r; end
    endcase
  end

  assign re_sum = ((rr_r - ii_r) >>> mpc_pkg::FRAC_BITS) + PW'(cr_r);
  assign im_sum = (prod >>> (mpc_pkg::FRAC_BITS - 1)) + PW'(ci_r);
  assign mag    = {1'b0, rr_r} + {1'b0, prod};

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[2:2];
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      mpc_pkg::REG_ITER_LIMIT: cfg_prdata = 32'(iter_limit_r);
      default:                 cfg_prdata = point_limit_r;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    iter_limit_nxt  = iter_limit_r;
    point_limit_nxt = point_limit_r;
    count_nxt       = count_r;
    n_nxt           = n_r;
    out_valid_nxt   = out_valid_r;
    cr_nxt          = cr_r;
    ci_nxt          = ci_r;
    zr_nxt          = zr_r;
    zi_nxt          = zi_r;
    rr_nxt          = rr_r;
    ii_nxt          = ii_r;
    out_data_nxt    = out_data_r;
    out_user_nxt    = out_user_r;

    if (cfg_wr) begin
      case (cfg_idx)
        mpc_pkg::REG_ITER_LIMIT: iter_limit_nxt = cfg_pwdata[mpc_pkg::ITER_W-1:0];
        default:                 point_limit_nxt = cfg_pwdata;
      endcase
    end

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cr_nxt = in_tdata[CW-1:0];
          ci_nxt = in_tdata[2*CW-1:CW];
          zr_nxt = '0;
          zi_nxt = '0;
          rr_nxt = '0;
          ii_nxt = '0;
          n_nxt  = '0;
          state_nxt = (iter_limit_r == '0) ? S_EMIT : S_RI;
        end
      end
      S_RI: state_nxt = S_UPD;
      S_UPD: begin
        zr_nxt    = sat32(re_sum);
        zi_nxt    = sat32(im_sum);
        state_nxt = S_RR;
      end
      S_RR: state_nxt = S_II;
      S_II: begin
        rr_nxt    = prod;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        ii_nxt = prod;
        n_nxt  = n_r + ITER_ONE;
        if (mag >= mpc_pkg::ESCAPE_SQ) state_nxt = S_IDLE;
        else if (n_nxt == iter_limit_r) state_nxt = S_EMIT;
        else state_nxt = S_RI;
      end
      S_EMIT: begin
        if (count_r >= point_limit_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {count_r, ci_r, cr_r};
          out_user_nxt  = ({1'b0, count_r} + {1'b0, COUNT_ONE}) == {1'b0, point_limit_r};
          count_nxt     = count_r + COUNT_ONE;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      iter_limit_r  <= mpc_pkg::ITER_LIMIT_RST;
      point_limit_r <= mpc_pkg::POINT_LIMIT_RST;
      count_r       <= '0;
      n_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      iter_limit_r  <= iter_limit_nxt;
      point_limit_r <= point_limit_nxt;
      count_r       <= count_nxt;
      n_r           <= n_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_r       <= cr_nxt;
    ci_r       <= ci_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    rr_r       <= rr_nxt;
    ii_r       <= ii_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
